// File: src/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// Holds the beat structs, the entry and cell command types and the codes.
// No dependencies.
package spq_pkg;

  localparam int VALUE_BITS    = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int COUNT_BITS    = 5;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef struct packed {
    op_e                      operation;
    logic [VALUE_BITS-1:0]    item_value;
    logic [PRIORITY_BITS-1:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    out_value;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [COUNT_BITS-1:0]    entry_count;
    logic                     is_empty;
    err_e                     error;
  } out_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // Broadcast to every cell of the chain in the same cycle
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t entry;
  } cell_cmd_t;

endpackage

// File: src/spq_cell.sv
// One cell of the sorted shift chain: holds one entry.
// Keeps, loads the new entry, or takes a neighbor's entry each cycle.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      prev_keep,
  input  entry_t    prev_entry,
  input  entry_t    next_entry,
  output logic      keep,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Stay in place when the stored entry ranks at or ahead of the new one
  assign keep  = occupied && (entry_r.prio <= cmd.entry.prio);
  assign entry = entry_r;

  // Insert: first non-kept cell takes the new entry, later ones shift down.
  // Remove: every cell takes its successor's entry.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.enq) begin
      if (!keep) begin
        entry_nxt = prev_keep ? cmd.entry : prev_entry;
      end
    end else if (cmd.deq) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: src/stable_priority_queue.sv
// Stable priority queue: a chain of CAPACITY cells kept in ascending priority.
// The result is strobed in the cycle after start; throughput: one beat per cycle,
// since every cell compares and shifts in parallel.
// busy stays low; the receiver cannot stall and takes each result as strobed.
// Reset (rst_n low, synchronous) empties the queue and clears the strobe.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           out_valid_r;
  out_t           out_r;
  out_t           out_nxt;
  cell_cmd_t      cmd;
  logic           accept;
  logic           full;
  logic           empty;
  logic [CW+4:0]  count_ext;
  logic           keep_vec [CAPACITY];
  entry_t         entry_vec [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);

  // Decode the beat into the broadcast command
  always_comb begin
    cmd.enq         = accept && (in_data.operation == OP_ENQ) && !full;
    cmd.deq         = accept && (in_data.operation == OP_DEQ) && !empty;
    cmd.entry.value = in_data.item_value;
    cmd.entry.prio  = in_data.priority_req;
  end

  // Build the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   pk;
    entry_t pe;
    entry_t ne;

    assign occ = (CW'(i) < count_r);
    if (i == 0) begin : g_first
      assign pk = 1'b1;
      assign pe = '0;
    end else begin : g_mid
      assign pk = keep_vec[i-1];
      assign pe = entry_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign ne = '0;
    end else begin : g_inner
      assign ne = entry_vec[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (occ),
      .prev_keep (pk),
      .prev_entry(pe),
      .next_entry(ne),
      .keep      (keep_vec[i]),
      .entry     (entry_vec[i])
    );
  end

  // Count update and result assembly
  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - CW'(1);
    end
    count_ext = {5'd0, count_nxt};

    out_nxt.out_value    = '0;
    out_nxt.out_priority = '0;
    out_nxt.error        = ERR_OK;
    if (cmd.deq) begin
      out_nxt.out_value    = entry_vec[0].value;
      out_nxt.out_priority = entry_vec[0].prio;
    end
    if (accept && (in_data.operation == OP_ENQ) && full) begin
      out_nxt.error = ERR_FULL;
    end else if (accept && (in_data.operation == OP_DEQ) && empty) begin
      out_nxt.error = ERR_EMPTY;
    end
    out_nxt.entry_count = count_ext[COUNT_BITS-1:0];
    out_nxt.is_empty    = (count_nxt == '0);
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat gave no result");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> (entry_vec[0].prio <= entry_vec[1].prio))
    else $error("head entries out of order");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.error == ERR_FULL)) |-> (count_r == CW'(CAPACITY)))
    else $error("enqueue refused while not full");
`endif

endmodule

// File: dv/stable_priority_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stable priority queue (stable_priority_queue).
// A directed table of beats comes first, then random fill and drain phases.
// Every result is checked against a sorted shadow queue or a typed-in result. Depends on spq_pkg.
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int RANDOM_BEATS   = 1280;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT       = 14;
  localparam int TAIL_CYCLES    = 4;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t golden;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  // Tag that travels with each beat: use the typed-in result instead of the shadow
  bit   beat_typed = 1'b0;
  out_t beat_golden = '0;

  entry_t     shadow_entries [CAPACITY];
  int         shadow_count = 0;
  out_t       results_due [$];
  stim_row_t  directed_rows [$];
  int         mismatch_count = 0;
  int         stall_cycles = 0;

  stable_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one beat to the shadow queue and return the result it should produce
  function automatic out_t step_shadow_queue(input in_t beat);
    out_t res;
    int   slot;
    int   k;
    res = '0;
    res.error = ERR_OK;
    if (beat.operation == OP_ENQ) begin
      if (shadow_count >= CAPACITY) begin
        res.error = ERR_FULL;
      end else begin
        // new entry goes behind every entry with priority less or equal
        slot = 0;
        while (slot < shadow_count && shadow_entries[slot].prio <= beat.priority_req)
          slot++;
        for (k = shadow_count; k > slot; k--)
          shadow_entries[k] = shadow_entries[k-1];
        shadow_entries[slot].value = beat.item_value;
        shadow_entries[slot].prio  = beat.priority_req;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.error = ERR_EMPTY;
      end else begin
        res.out_value    = shadow_entries[0].value;
        res.out_priority = shadow_entries[0].prio;
        for (k = 1; k < shadow_count; k++)
          shadow_entries[k-1] = shadow_entries[k];
        shadow_count--;
      end
    end
    res.entry_count = shadow_count[COUNT_BITS-1:0];
    res.is_empty    = (shadow_count == 0);
    return res;
  endfunction

  function automatic void add_row(input op_e op, input logic [VALUE_BITS-1:0] value,
                                  input logic [PRIORITY_BITS-1:0] prio, input bit typed,
                                  input out_t golden);
    stim_row_t row;
    row.beat.operation    = op;
    row.beat.item_value   = value;
    row.beat.priority_req = prio;
    row.typed  = typed;
    row.golden = golden;
    directed_rows.push_back(row);
  endfunction

  // Present one beat, optionally after random idle cycles, and hold it until taken
  task automatic send_beat(input in_t beat, input bit typed, input out_t golden,
                           input bit allow_idle);
    while (allow_idle && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_data     <= beat;
    beat_typed  <= typed;
    beat_golden <= golden;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic pause_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Track accepted beats, check each strobed result, and watch for a hang
  always @(posedge clk) begin
    out_t want;
    out_t predicted;
    bit   moved;
    if (rst_n) begin
      moved = 1'b0;
      if (start && !busy) begin
        predicted = step_shadow_queue(in_data);
        results_due.push_back(beat_typed ? beat_golden : predicted);
        moved = 1'b1;
      end
      if (out_valid) begin
        moved = 1'b1;
        if (results_due.size() == 0) begin
          $error("result beat with no expectation pending");
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          if (out_data.out_value !== want.out_value) begin
            $error("out_value: expected %0h, got %0h", want.out_value, out_data.out_value);
            mismatch_count++;
          end
          if (out_data.out_priority !== want.out_priority) begin
            $error("out_priority: expected %0h, got %0h",
                   want.out_priority, out_data.out_priority);
            mismatch_count++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, out_data.entry_count);
            mismatch_count++;
          end
          if (out_data.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, out_data.is_empty);
            mismatch_count++;
          end
          if (out_data.error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, out_data.error);
            mismatch_count++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    in_t  beat;
    out_t golden;
    int   n;
    bit   fill_phase;
    bit   deq;
    int   pick;
    logic [PRIORITY_BITS-1:0] prio;

    // Dequeue on empty, fill with extremes and ties, overflow, then drain part way
    golden = '0;
    golden.is_empty = 1'b1;
    golden.error    = ERR_EMPTY;
    add_row(OP_DEQ, 16'hDEAD, 8'h5A, 1'b1, golden);
    add_row(OP_ENQ, 16'hFFFF, 8'hFF, 1'b0, '0);
    add_row(OP_ENQ, 16'h0000, 8'h00, 1'b0, '0);
    add_row(OP_ENQ, 16'h1234, 8'h80, 1'b0, '0);
    add_row(OP_ENQ, 16'hABCD, 8'h80, 1'b0, '0);
    add_row(OP_ENQ, 16'h5555, 8'h80, 1'b0, '0);
    add_row(OP_ENQ, 16'hAAAA, 8'h00, 1'b0, '0);
    add_row(OP_ENQ, 16'h0001, 8'hFF, 1'b0, '0);
    add_row(OP_ENQ, 16'h8000, 8'h7F, 1'b0, '0);
    add_row(OP_ENQ, 16'h7FFF, 8'h01, 1'b0, '0);
    add_row(OP_ENQ, 16'h00FF, 8'h01, 1'b0, '0);
    add_row(OP_ENQ, 16'hFF00, 8'hFE, 1'b0, '0);
    add_row(OP_ENQ, 16'h0F0F, 8'h55, 1'b0, '0);
    add_row(OP_ENQ, 16'hF0F0, 8'hAA, 1'b0, '0);
    add_row(OP_ENQ, 16'h3C3C, 8'h00, 1'b0, '0);
    add_row(OP_ENQ, 16'hC3C3, 8'h80, 1'b0, '0);
    add_row(OP_ENQ, 16'h6666, 8'hFF, 1'b0, '0);
    golden = '0;
    golden.entry_count = 5'd16;
    golden.error       = ERR_FULL;
    add_row(OP_ENQ, 16'h9999, 8'h00, 1'b1, golden);
    repeat (6) add_row(OP_DEQ, 16'hFFFF, 8'hFF, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].golden,
                1'b1);
    pause_until_drained();

    // Alternate fill-heavy and drain-heavy phases so full and empty both recur
    fill_phase = 1'b0;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0) fill_phase = ~fill_phase;
      if (n == 500) pause_until_drained();
      if ($urandom_range(9) == 0)
        deq = 1'($urandom_range(1));
      else
        deq = ($urandom_range(99) < 75) ? !fill_phase : fill_phase;
      pick = $urandom_range(9);
      if (pick < 4)
        prio = PRIORITY_BITS'($urandom_range(3));
      else if (pick == 4)
        prio = $urandom_range(1) ? 8'hFF : 8'h00;
      else
        prio = PRIORITY_BITS'($urandom_range(255));
      beat.operation    = deq ? OP_DEQ : OP_ENQ;
      beat.item_value   = VALUE_BITS'($urandom_range(16'hFFFF));
      beat.priority_req = prio;
      send_beat(beat, 1'b0, '0, !(n >= 700 && n < 1000));
    end

    // Drain, let the pipeline settle, then report
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
